### sv/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg - shared definitions for the min-pooling downscaler
// Widths, reset values, register indexes and the per-item control struct
// passed from the counter stage to the merge stage.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int PIX_W      = 8;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // configuration port
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int RATIO_CFG_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_POOL_RATIO   = 2'd2
  } cfg_idx_e;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_RATIO_DEF = 64;

  // frame height limit and the counters that follow from it
  localparam int MAX_HEIGHT = 4096;
  localparam int H_W        = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register reset values
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int RATIO_RST  = 32;

  // zero reads as one, values above the limit saturate
  function automatic int unsigned clamp_cfg(input int unsigned v, input int unsigned hi);
    int unsigned res;
    if (v == 0) begin
      res = 1;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // control for one pixel that closes a block row segment
  typedef struct packed {
    logic             wr;          // segment end: line store update
    logic             use_ram;     // not the first row of the block
    logic             emit;        // last row of the block: result goes out
    logic             last_row;    // last whole block of the output row
    logic             last_frame;  // last whole block of the frame
    logic [PIX_W-1:0] row_min;     // minimum along this row segment
  } seg_t;

endpackage

### sv/min_pool_downscale.sv
// ----------------------------------------------------------------------------
// min_pool_downscale - min-pooling image downscaler
// Takes 8-bit grayscale pixels in raster order and gives one item per whole
// pool_ratio x pool_ratio block: the minimum pixel of that block.
// ----------------------------------------------------------------------------
//
//  channel   direction  item                  signals
//  s_axis    in         one pixel             tvalid, tready, tdata
//  m_axis    out        one block minimum     tvalid, tready, tdata, tuser, tlast
//  cfg       in         register write        cfg_we_i, cfg_idx_i, cfg_data_i
//
//  one pixel per clock while s_axis_tready is high; a block result passes the
//  merge-stage register and the result register before it shows on m_axis
//  per-pixel path: block-bound add/compare in the counter stage, then a
//  line-store read, one compare and the write-back in the merge stage
//  reset: counters at frame start, registers at 640 x 480 ratio 32; the line
//  store is not cleared, each entry is written on a block's first row first
//  stalls: s_axis_tready drops only while a line-store update waits behind a
//  full result register that m_axis does not take
//
module min_pool_downscale #(
  parameter int MAX_WIDTH = mpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RATIO = mpd_pkg::MAX_RATIO_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mpd_pkg::PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel
  // block result
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mpd_pkg::PIX_W-1:0]        m_axis_tdata,   // [7:0] min_value
  output logic                             m_axis_tuser,   // [0] last_in_row
  output logic                             m_axis_tlast,   // last_in_frame
  // register writes
  input  logic                             cfg_we_i,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mpd_pkg::CFG_W-1:0]        cfg_data_i
);
  import mpd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int IW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_RATIO + 1);

  // registers hold the clamped values
  logic [CW-1:0]  width_q;
  logic [H_W-1:0] height_q;
  logic [RW-1:0]  ratio_q;
  logic           restart;

  logic             accept;
  seg_t             seg;
  logic [IW-1:0]    idx;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic [PIX_W-1:0] rd_data;

  // any write to a known register restarts the frame
  always_comb begin
    unique case (cfg_idx_i)
      CFG_IMAGE_WIDTH,
      CFG_IMAGE_HEIGHT,
      CFG_POOL_RATIO: restart = cfg_we_i;
      default:        restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(clamp_cfg(WIDTH_RST, MAX_WIDTH));
      height_q <= H_W'(clamp_cfg(HEIGHT_RST, MAX_HEIGHT));
      ratio_q  <= RW'(clamp_cfg(RATIO_RST, MAX_RATIO));
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= CW'(clamp_cfg(32'(cfg_data_i), MAX_WIDTH));
        CFG_IMAGE_HEIGHT: height_q <= H_W'(clamp_cfg(32'(cfg_data_i), MAX_HEIGHT));
        CFG_POOL_RATIO:   ratio_q  <= RW'(clamp_cfg(32'(cfg_data_i[RATIO_CFG_W-1:0]),
                                                     MAX_RATIO));
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  // raster position, block offsets and running row minimum
  mpd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RATIO (MAX_RATIO)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .advance_i (accept),
    .pixel_i   (s_axis_tdata),
    .width_i   (width_q),
    .height_i  (height_q),
    .ratio_i   (ratio_q),
    .seg_o     (seg),
    .idx_o     (idx)
  );

  // line store: one partial minimum per output column
  mpd_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept & seg.wr),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  // column merge, write-back and result register
  mpd_merge #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .seg_i            (seg),
    .idx_i            (idx),
    .in_ready_o       (s_axis_tready),
    .rd_data_i        (rd_data),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_min_o        (m_axis_tdata),
    .out_last_row_o   (m_axis_tuser),
    .out_last_frame_o (m_axis_tlast)
  );

endmodule

### sv/mpd_ram.sv
// ----------------------------------------------------------------------------
// mpd_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mpd_ctrl.sv
// ----------------------------------------------------------------------------
// mpd_ctrl - position counters and row running minimum
// Tracks the raster position, block offsets and block start positions, and
// classifies each pixel; whole-block checks use block starts instead of a divide.
// ----------------------------------------------------------------------------
module mpd_ctrl #(
  parameter int MAX_WIDTH = mpd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RATIO = mpd_pkg::MAX_RATIO_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 restart_i,
  input  logic                                 advance_i,
  input  logic [mpd_pkg::PIX_W-1:0]            pixel_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       width_i,
  input  logic [mpd_pkg::H_W-1:0]              height_i,
  input  logic [$clog2(MAX_RATIO+1)-1:0]       ratio_i,
  output mpd_pkg::seg_t                        seg_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         idx_o
);
  import mpd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int IW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_RATIO + 1);
  localparam int OW  = $clog2(MAX_RATIO);
  localparam int CSW = $clog2(MAX_WIDTH + 2 * MAX_RATIO + 1);
  localparam int HSW = $clog2(MAX_HEIGHT + 2 * MAX_RATIO + 1);

  logic [IW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [OW-1:0]    offx_q, offx_d;
  logic [OW-1:0]    offy_q, offy_d;
  logic [IW-1:0]    ocol_q, ocol_d;
  logic [CW-1:0]    bstart_q, bstart_d;
  logic [H_W-1:0]   rstart_q, rstart_d;
  logic [PIX_W-1:0] run_min_q, run_min_d;

  logic [CSW-1:0]   b1, b2;
  logic [HSW-1:0]   r1, r2;
  logic             col_ok, row_ok, active;
  logic             x_end, y_end, col_end, row_end;
  logic             last_row, last_blk_row;
  logic [PIX_W-1:0] row_min;

  // block bounds: a block is whole when its far edge stays inside the frame
  assign b1 = CSW'(bstart_q) + CSW'(ratio_i);
  assign b2 = b1 + CSW'(ratio_i);
  assign r1 = HSW'(rstart_q) + HSW'(ratio_i);
  assign r2 = r1 + HSW'(ratio_i);

  assign col_ok       = b1 <= CSW'(width_i);
  assign row_ok       = r1 <= HSW'(height_i);
  assign last_row     = b2 > CSW'(width_i);
  assign last_blk_row = r2 > HSW'(height_i);
  assign active       = col_ok & row_ok;

  assign x_end   = (RW'(offx_q) + RW'(1'b1)) >= ratio_i;
  assign y_end   = (RW'(offy_q) + RW'(1'b1)) >= ratio_i;
  assign col_end = (CW'(col_q) + CW'(1'b1)) >= width_i;
  assign row_end = (H_W'(row_q) + H_W'(1'b1)) >= height_i;

  assign row_min = ((offx_q == '0) || (pixel_i < run_min_q)) ? pixel_i : run_min_q;

  always_comb begin
    seg_o.wr         = active & x_end;
    seg_o.use_ram    = offy_q != '0;
    seg_o.emit       = y_end;
    seg_o.last_row   = last_row;
    seg_o.last_frame = last_row & last_blk_row;
    seg_o.row_min    = row_min;
  end

  assign idx_o = ocol_q;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    offx_d    = offx_q;
    offy_d    = offy_q;
    ocol_d    = ocol_q;
    bstart_d  = bstart_q;
    rstart_d  = rstart_q;
    run_min_d = run_min_q;
    if (restart_i) begin
      col_d     = '0;
      row_d     = '0;
      offx_d    = '0;
      offy_d    = '0;
      ocol_d    = '0;
      bstart_d  = '0;
      rstart_d  = '0;
      run_min_d = PIX_MAX;
    end else if (advance_i) begin
      if (active) begin
        if (x_end) begin
          offx_d    = '0;
          ocol_d    = ocol_q + IW'(1'b1);
          bstart_d  = b1[CW-1:0];
          run_min_d = PIX_MAX;
        end else begin
          offx_d    = offx_q + OW'(1'b1);
          run_min_d = row_min;
        end
      end
      if (col_end) begin
        col_d     = '0;
        offx_d    = '0;
        ocol_d    = '0;
        bstart_d  = '0;
        run_min_d = PIX_MAX;
        if (row_ok) begin
          if (y_end) begin
            offy_d   = '0;
            rstart_d = r1[H_W-1:0];
          end else begin
            offy_d = offy_q + OW'(1'b1);
          end
        end
        if (row_end) begin
          row_d    = '0;
          offy_d   = '0;
          rstart_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1'b1);
        end
      end else begin
        col_d = col_q + IW'(1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      offx_q    <= '0;
      offy_q    <= '0;
      ocol_q    <= '0;
      bstart_q  <= '0;
      rstart_q  <= '0;
      run_min_q <= PIX_MAX;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      offx_q    <= offx_d;
      offy_q    <= offy_d;
      ocol_q    <= ocol_d;
      bstart_q  <= bstart_d;
      rstart_q  <= rstart_d;
      run_min_q <= run_min_d;
    end
  end

endmodule

### sv/mpd_merge.sv
// ----------------------------------------------------------------------------
// mpd_merge - column merge and result register
// Combines a row segment minimum with the line store entry, writes the entry
// back and holds the result item until the output side takes it.
// ----------------------------------------------------------------------------
module mpd_merge #(
  parameter int MAX_WIDTH = mpd_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // from the counter stage
  input  logic                             accept_i,
  input  mpd_pkg::seg_t                    seg_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]     idx_i,
  output logic                             in_ready_o,
  // line store
  input  logic [mpd_pkg::PIX_W-1:0]        rd_data_i,
  output logic                             wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr_o,
  output logic [mpd_pkg::PIX_W-1:0]        wr_data_o,
  // result
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [mpd_pkg::PIX_W-1:0]        out_min_o,
  output logic                             out_last_row_o,
  output logic                             out_last_frame_o
);
  import mpd_pkg::*;

  localparam int IW = $clog2(MAX_WIDTH);

  logic             s1_valid_q, s1_valid_d;
  seg_t             s1_seg_q;
  logic [IW-1:0]    s1_idx_q;
  logic             byp_q, byp_d;
  logic [PIX_W-1:0] byp_data_q;
  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_min_q;
  logic             out_last_row_q, out_last_frame_q;

  logic             s1_adv, load_s1;
  logic [PIX_W-1:0] col_min, merged;

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign load_s1    = accept_i & seg_i.wr;

  // entry written this cycle is not yet in the read data
  assign col_min = byp_q ? byp_data_q : rd_data_i;
  assign merged  = (s1_seg_q.use_ram && (col_min < s1_seg_q.row_min)) ?
                   col_min : s1_seg_q.row_min;

  assign wr_en_o   = s1_adv & s1_seg_q.wr;
  assign wr_addr_o = s1_idx_q;
  assign wr_data_o = merged;

  assign byp_d = load_s1 & wr_en_o & (idx_i == s1_idx_q);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load_s1) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_seg_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      s1_seg_q   <= seg_i;
      s1_idx_q   <= idx_i;
      byp_q      <= byp_d;
      byp_data_q <= merged;
    end
    if (s1_adv && s1_seg_q.emit) begin
      out_min_q        <= merged;
      out_last_row_q   <= s1_seg_q.last_row;
      out_last_frame_q <= s1_seg_q.last_frame;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_min_o        = out_min_q;
  assign out_last_row_o   = out_last_row_q;
  assign out_last_frame_o = out_last_frame_q;

endmodule
